// ===== rtl/core/lfp_pkg.sv =====
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared types, constants and the CRC-8 step for the lidar frame parser.
// ----------------------------------------------------------------------------
package lfp_pkg;

	localparam int unsigned POINTS_DEF   = 12;
	localparam logic [7:0]  HDR_BYTE     = 8'h54;
	localparam logic [7:0]  VERLEN_BYTE  = 8'h2C;
	localparam logic [7:0]  POLY_RESET   = 8'h4D;

	typedef enum logic [3:0] {
		PH_HEADER,
		PH_VERLEN,
		PH_SPD_L,
		PH_SPD_H,
		PH_SA_L,
		PH_SA_H,
		PH_DIST_L,
		PH_DIST_H,
		PH_INTENS,
		PH_EA_L,
		PH_EA_H,
		PH_TS_L,
		PH_TS_H,
		PH_CRC,
		PH_DRAIN
	} phase_t;

	typedef enum logic [1:0] {
		CRC_HOLD,
		CRC_START,
		CRC_STEP
	} crc_op_t;

	typedef enum logic [3:0] {
		FLD_NONE,
		FLD_SPD_L,
		FLD_SPD_H,
		FLD_SA_L,
		FLD_SA_H,
		FLD_DIST_L,
		FLD_DIST_H,
		FLD_EA_L,
		FLD_EA_H,
		FLD_TS_L,
		FLD_TS_H
	} fld_t;

	typedef struct packed {
		crc_op_t crc_op;
		fld_t    fld;
		logic    wr_point;
		logic    cnt_clr;
		logic    cnt_inc;
		logic    drain_start;
		logic    err_emit;
	} cmd_t;

	typedef struct packed {
		logic hdr_match;
		logic ver_match;
		logic crc_ok;
		logic last_point;
		logic out_free;
		logic drain_end;
	} sts_t;

	// One byte of an MSB-first, non-reflected CRC-8.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] din,
	                                         input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ din;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/lfp_ram.sv =====
// ----------------------------------------------------------------------------
// lfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold the last read word until the next read
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/lfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfp_ctrl
// Frame parsing state machine: walks the packet byte by byte, issues
// datapath commands and waits for the point drain after a good CRC.
// ----------------------------------------------------------------------------
module lfp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lfp_pkg::sts_t sts,
	output lfp_pkg::cmd_t cmd
);
	import lfp_pkg::*;

	phase_t state_q;
	phase_t state_nxt;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_HEADER;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign accept = in_valid & in_ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			PH_VERLEN: if (accept) state_nxt = sts.ver_match ? PH_SPD_L : PH_HEADER;
			PH_SPD_L:  if (accept) state_nxt = PH_SPD_H;
			PH_SPD_H:  if (accept) state_nxt = PH_SA_L;
			PH_SA_L:   if (accept) state_nxt = PH_SA_H;
			PH_SA_H:   if (accept) state_nxt = PH_DIST_L;
			PH_DIST_L: if (accept) state_nxt = PH_DIST_H;
			PH_DIST_H: if (accept) state_nxt = PH_INTENS;
			PH_INTENS: if (accept) state_nxt = sts.last_point ? PH_EA_L : PH_DIST_L;
			PH_EA_L:   if (accept) state_nxt = PH_EA_H;
			PH_EA_H:   if (accept) state_nxt = PH_TS_L;
			PH_TS_L:   if (accept) state_nxt = PH_TS_H;
			PH_TS_H:   if (accept) state_nxt = PH_CRC;
			PH_CRC:    if (accept) state_nxt = sts.crc_ok ? PH_DRAIN : PH_HEADER;
			PH_DRAIN:  if (sts.drain_end) state_nxt = PH_HEADER;
			default:   if (accept) state_nxt = sts.hdr_match ? PH_VERLEN : PH_HEADER;
		endcase
	end

	// outputs
	always_comb begin
		in_ready        = 1'b1;
		cmd.crc_op      = CRC_HOLD;
		cmd.fld         = FLD_NONE;
		cmd.wr_point    = 1'b0;
		cmd.cnt_clr     = 1'b0;
		cmd.cnt_inc     = 1'b0;
		cmd.drain_start = 1'b0;
		cmd.err_emit    = 1'b0;
		case (state_q)
			PH_VERLEN: if (accept && sts.ver_match) cmd.crc_op = CRC_STEP;
			PH_SPD_L: if (accept) begin
				cmd.crc_op = CRC_STEP;
				cmd.fld    = FLD_SPD_L;
			end
			PH_SPD_H: if (accept) begin
				cmd.crc_op = CRC_STEP;
				cmd.fld    = FLD_SPD_H;
			end
			PH_SA_L: if (accept) begin
				cmd.crc_op = CRC_STEP;
				cmd.fld    = FLD_SA_L;
			end
			PH_SA_H: if (accept) begin
				cmd.crc_op  = CRC_STEP;
				cmd.fld     = FLD_SA_H;
				cmd.cnt_clr = 1'b1;
			end
			PH_DIST_L: if (accept) begin
				cmd.crc_op = CRC_STEP;
				cmd.fld    = FLD_DIST_L;
			end
			PH_DIST_H: if (accept) begin
				cmd.crc_op = CRC_STEP;
				cmd.fld    = FLD_DIST_H;
			end
			PH_INTENS: if (accept) begin
				cmd.crc_op   = CRC_STEP;
				cmd.wr_point = 1'b1;
				cmd.cnt_inc  = ~sts.last_point;
			end
			PH_EA_L: if (accept) begin
				cmd.crc_op = CRC_STEP;
				cmd.fld    = FLD_EA_L;
			end
			PH_EA_H: if (accept) begin
				cmd.crc_op = CRC_STEP;
				cmd.fld    = FLD_EA_H;
			end
			PH_TS_L: if (accept) begin
				cmd.crc_op = CRC_STEP;
				cmd.fld    = FLD_TS_L;
			end
			PH_TS_H: if (accept) begin
				cmd.crc_op = CRC_STEP;
				cmd.fld    = FLD_TS_H;
			end
			PH_CRC: begin
				// the error result goes straight to the output register
				in_ready = sts.out_free;
				if (accept) begin
					cmd.drain_start = sts.crc_ok;
					cmd.err_emit    = ~sts.crc_ok;
				end
			end
			PH_DRAIN: in_ready = 1'b0;
			default: if (accept && sts.hdr_match) cmd.crc_op = CRC_START;
		endcase
	end

endmodule

// ===== rtl/core/lfp_dpath.sv =====
// ----------------------------------------------------------------------------
// lfp_dpath
// Parser datapath: CRC register, frame field registers, point store and
// the output register that the point drain and the error result feed.
// ----------------------------------------------------------------------------
module lfp_dpath #(
	parameter int unsigned POINTS_PER_FRAME = lfp_pkg::POINTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_write,
	input  logic [7:0]    cfg_data,
	input  logic [7:0]    rx_byte,
	input  lfp_pkg::cmd_t cmd,
	output lfp_pkg::sts_t sts,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          status,
	output logic [15:0]   rotation_speed,
	output logic [15:0]   first_angle,
	output logic [15:0]   final_angle,
	output logic [15:0]   stamp,
	output logic [3:0]    point_number,
	output logic [15:0]   distance_mm,
	output logic [7:0]    strength,
	output logic          last
);
	import lfp_pkg::*;

	localparam int unsigned IDX_W = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1;
	localparam int unsigned CNT_W = $clog2(POINTS_PER_FRAME + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS_PER_FRAME - 1);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(POINTS_PER_FRAME);

	logic [7:0]       poly_q;
	logic [7:0]       crc_q;
	logic [15:0]      speed_q;
	logic [15:0]      start_q;
	logic [15:0]      end_q;
	logic [15:0]      stamp_q;
	logic [15:0]      dist_q;
	logic [IDX_W-1:0] wr_idx_q;

	logic             drain_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic             rd_pend_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [23:0]      rd_data;
	logic             rd_issue;
	logic             consume;
	logic             out_free;

	logic             out_valid_q;
	logic             status_q;
	logic [15:0]      speed_out_q;
	logic [15:0]      start_out_q;
	logic [15:0]      end_out_q;
	logic [15:0]      stamp_out_q;
	logic [3:0]       pnum_q;
	logic [15:0]      dist_out_q;
	logic [7:0]       str_q;
	logic             last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= POLY_RESET;
		end else if (cfg_write) begin
			poly_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.crc_op)
			CRC_START: crc_q <= crc8_byte(8'h00, rx_byte, poly_q);
			CRC_STEP:  crc_q <= crc8_byte(crc_q, rx_byte, poly_q);
			default:   crc_q <= crc_q;
		endcase
		case (cmd.fld)
			FLD_SPD_L:  speed_q <= {8'h00, rx_byte};
			FLD_SPD_H:  speed_q[15:8] <= rx_byte;
			FLD_SA_L:   start_q <= {8'h00, rx_byte};
			FLD_SA_H:   start_q[15:8] <= rx_byte;
			FLD_DIST_L: dist_q <= {8'h00, rx_byte};
			FLD_DIST_H: dist_q[15:8] <= rx_byte;
			FLD_EA_L:   end_q <= {8'h00, rx_byte};
			FLD_EA_H:   end_q[15:8] <= rx_byte;
			FLD_TS_L:   stamp_q <= {8'h00, rx_byte};
			FLD_TS_H:   stamp_q[15:8] <= rx_byte;
			default:    ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
		end else if (cmd.cnt_clr) begin
			wr_idx_q <= '0;
		end else if (cmd.cnt_inc) begin
			wr_idx_q <= wr_idx_q + 1'b1;
		end
	end

	// distance and intensity of one point share a word
	lfp_ram #(
		.WIDTH (24),
		.DEPTH (POINTS_PER_FRAME),
		.AW    (IDX_W)
	) u_point_ram (
		.clk   (clk),
		.we    (cmd.wr_point),
		.waddr (wr_idx_q),
		.wdata ({dist_q, rx_byte}),
		.re    (rd_issue),
		.raddr (rd_cnt_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	assign out_free = ~out_valid_q | out_ready;
	assign consume  = rd_pend_s1 & out_free;
	// next read once the pending word moves to the output register
	assign rd_issue = drain_q & (rd_cnt_q != CNT_END) & (~rd_pend_s1 | consume);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q    <= 1'b0;
			rd_cnt_q   <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			if (cmd.drain_start) begin
				drain_q  <= 1'b1;
				rd_cnt_q <= '0;
			end else begin
				if (sts.drain_end) begin
					drain_q <= 1'b0;
				end
				if (rd_issue) begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
				end
			end
			if (rd_issue) begin
				rd_pend_s1 <= 1'b1;
			end else if (consume) begin
				rd_pend_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_idx_s1 <= rd_cnt_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume || cmd.err_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume || cmd.err_emit) begin
			speed_out_q <= speed_q;
			start_out_q <= start_q;
			end_out_q   <= end_q;
			stamp_out_q <= stamp_q;
		end
		if (consume) begin
			status_q   <= 1'b0;
			pnum_q     <= 4'(rd_idx_s1);
			dist_out_q <= rd_data[23:8];
			str_q      <= rd_data[7:0];
			last_q     <= (rd_idx_s1 == LAST_IDX);
		end else if (cmd.err_emit) begin
			status_q   <= 1'b1;
			pnum_q     <= 4'd0;
			dist_out_q <= 16'd0;
			str_q      <= 8'd0;
			last_q     <= 1'b1;
		end
	end

	assign sts.hdr_match  = (rx_byte == HDR_BYTE);
	assign sts.ver_match  = (rx_byte == VERLEN_BYTE);
	assign sts.crc_ok     = (rx_byte == crc_q);
	assign sts.last_point = (wr_idx_q == LAST_IDX);
	assign sts.out_free   = out_free;
	assign sts.drain_end  = consume & (rd_idx_s1 == LAST_IDX);

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign rotation_speed = speed_out_q;
	assign first_angle    = start_out_q;
	assign final_angle    = end_out_q;
	assign stamp          = stamp_out_q;
	assign point_number   = pnum_q;
	assign distance_mm    = dist_out_q;
	assign strength       = str_q;
	assign last           = last_q;

endmodule

// ===== rtl/core/lidar_frame_parser_crc8.sv =====
// ----------------------------------------------------------------------------
// lidar_frame_parser_crc8
// Parses a serial lidar scan packet with a running CRC-8 and returns one
// result per point of a good frame, or one error result on a CRC mismatch.
// ----------------------------------------------------------------------------
// Every byte but the CRC byte is taken in one cycle, back to back.
// Good CRC byte: the first point result passes through the drain flag, the RAM
// read register and the output register, then one point per cycle follows while
// out_ready is high; no byte is taken until the last point is in the output register.
// Bad CRC byte: the error result shows the next cycle.
// Reset clears the parser state and output valid and sets the polynomial to
// 0x4D; the point RAM is not cleared.
module lidar_frame_parser_crc8 #(
	parameter int unsigned POINTS_PER_FRAME = lfp_pkg::POINTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [15:0] rotation_speed,
	output logic [15:0] first_angle,
	output logic [15:0] final_angle,
	output logic [15:0] stamp,
	output logic [3:0]  point_number,
	output logic [15:0] distance_mm,
	output logic [7:0]  strength,
	output logic        last
);
	import lfp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lfp_dpath #(
		.POINTS_PER_FRAME (POINTS_PER_FRAME)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_data       (cfg_data),
		.rx_byte        (rx_byte),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.rotation_speed (rotation_speed),
		.first_angle    (first_angle),
		.final_angle    (final_angle),
		.stamp          (stamp),
		.point_number   (point_number),
		.distance_mm    (distance_mm),
		.strength       (strength),
		.last           (last)
	);

endmodule

// ===== test/lidar_frame_parser_crc8_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_frame_parser_crc8_test
// Drives lidar scan packets, good and broken, through the parser byte by byte
// under random sender gaps and receiver stalls, predicts the point and error
// results in a scoreboard, and checks every result field by field. The CRC
// polynomial is changed between phases while no result is outstanding.
// ----------------------------------------------------------------------------
module lidar_frame_parser_crc8_test;

	import lfp_pkg::*;

	localparam int POINTS      = POINTS_DEF;
	localparam int FRAME_BYTES = 11 + 3 * POINTS;
	localparam int DRAIN_WAIT  = POINTS + 8;

	typedef struct packed {
		logic        status;
		logic [15:0] speed;
		logic [15:0] start_ang;
		logic [15:0] end_ang;
		logic [15:0] tstamp;
		logic [3:0]  idx;
		logic [15:0] range_mm;
		logic [7:0]  echo;
		logic        last_flag;
	} scan_result_t;

	typedef struct {
		logic [15:0] speed;
		logic [15:0] start_ang;
		logic [15:0] end_ang;
		logic [15:0] tstamp;
		logic [15:0] range_mm [POINTS];
		logic [7:0]  echo [POINTS];
	} scan_frame_t;

	class frame_scoreboard;
		logic [7:0]   poly = POLY_RESET;
		phase_t       parse_st = PH_HEADER;
		logic [3:0]   pt_idx = '0;
		logic [7:0]   crc = '0;
		logic [15:0]  speed = '0;
		logic [15:0]  start_ang = '0;
		logic [15:0]  end_ang = '0;
		logic [15:0]  tstamp = '0;
		logic [15:0]  range_store [POINTS];
		logic [7:0]   echo_store [POINTS];
		scan_result_t pending [$];
		int           errors = 0;

		static function logic [7:0] crc_next(logic [7:0] cur, logic [7:0] b, logic [7:0] gen);
			logic [7:0] c;
			logic       msb;
			c = cur ^ b;
			for (int k = 0; k < 8; k++) begin
				msb = c[7];
				c = {c[6:0], 1'b0};
				if (msb)
					c = c ^ gen;
			end
			return c;
		endfunction

		function void add_result(logic st, logic [3:0] i, logic [15:0] r, logic [7:0] e,
		                         logic lf);
			scan_result_t x;
			x.status    = st;
			x.speed     = speed;
			x.start_ang = start_ang;
			x.end_ang   = end_ang;
			x.tstamp    = tstamp;
			x.idx       = i;
			x.range_mm  = r;
			x.echo      = e;
			x.last_flag = lf;
			pending.push_back(x);
		endfunction

		// Advance the parser by one accepted byte and queue what it produces.
		function void note_byte(logic [7:0] b);
			logic [7:0] nxt;
			nxt = crc_next(crc, b, poly);
			case (parse_st)
				PH_VERLEN: begin
					if (b == VERLEN_BYTE) begin
						crc = nxt;
						speed = '0;
						parse_st = PH_SPD_L;
					end else begin
						// the rejected byte is not tried as a header
						parse_st = PH_HEADER;
					end
				end
				PH_SPD_L: begin
					crc = nxt;
					speed = {8'h00, b};
					parse_st = PH_SPD_H;
				end
				PH_SPD_H: begin
					crc = nxt;
					speed[15:8] = b;
					parse_st = PH_SA_L;
				end
				PH_SA_L: begin
					crc = nxt;
					start_ang = {8'h00, b};
					parse_st = PH_SA_H;
				end
				PH_SA_H: begin
					crc = nxt;
					start_ang[15:8] = b;
					pt_idx = '0;
					parse_st = PH_DIST_L;
				end
				PH_DIST_L: begin
					crc = nxt;
					range_store[pt_idx] = {8'h00, b};
					parse_st = PH_DIST_H;
				end
				PH_DIST_H: begin
					crc = nxt;
					range_store[pt_idx][15:8] = b;
					parse_st = PH_INTENS;
				end
				PH_INTENS: begin
					crc = nxt;
					echo_store[pt_idx] = b;
					if (pt_idx == POINTS - 1) begin
						parse_st = PH_EA_L;
					end else begin
						pt_idx = pt_idx + 1;
						parse_st = PH_DIST_L;
					end
				end
				PH_EA_L: begin
					crc = nxt;
					end_ang = {8'h00, b};
					parse_st = PH_EA_H;
				end
				PH_EA_H: begin
					crc = nxt;
					end_ang[15:8] = b;
					parse_st = PH_TS_L;
				end
				PH_TS_L: begin
					crc = nxt;
					tstamp = {8'h00, b};
					parse_st = PH_TS_H;
				end
				PH_TS_H: begin
					crc = nxt;
					tstamp[15:8] = b;
					parse_st = PH_CRC;
				end
				PH_CRC: begin
					if (crc == b) begin
						for (int i = 0; i < POINTS; i++)
							add_result(1'b0, 4'(i), range_store[i], echo_store[i],
							           i == POINTS - 1);
					end else begin
						add_result(1'b1, 4'd0, 16'h0000, 8'h00, 1'b1);
					end
					parse_st = PH_HEADER;
				end
				default: begin
					if (b == HDR_BYTE) begin
						crc = crc_next(8'h00, b, poly);
						parse_st = PH_VERLEN;
					end else begin
						parse_st = PH_HEADER;
					end
				end
			endcase
		endfunction

		function void cmp_field(string what, logic [15:0] e, logic [15:0] a);
			if (e !== a) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, e, a);
			end
		endfunction

		function void check_result(scan_result_t got);
			scan_result_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got %p", $time, got);
				return;
			end
			want = pending.pop_front();
			cmp_field("status", want.status, got.status);
			cmp_field("rotation_speed", want.speed, got.speed);
			cmp_field("first_angle", want.start_ang, got.start_ang);
			cmp_field("final_angle", want.end_ang, got.end_ang);
			cmp_field("stamp", want.tstamp, got.tstamp);
			cmp_field("point_number", want.idx, got.idx);
			cmp_field("distance_mm", want.range_mm, got.range_mm);
			cmp_field("strength", want.echo, got.echo);
			cmp_field("last", want.last_flag, got.last_flag);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_write;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic        status;
	logic [15:0] rotation_speed;
	logic [15:0] first_angle;
	logic [15:0] final_angle;
	logic [15:0] stamp;
	logic [3:0]  point_number;
	logic [15:0] distance_mm;
	logic [7:0]  strength;
	logic        last;

	frame_scoreboard sb = new();
	int burst_left = 0;
	int frame_bytes = 0;

	lidar_frame_parser_crc8 u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.rotation_speed (rotation_speed),
		.first_angle    (first_angle),
		.final_angle    (final_angle),
		.stamp          (stamp),
		.point_number   (point_number),
		.distance_mm    (distance_mm),
		.strength       (strength),
		.last           (last)
	);

	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("lidar_frame_parser_crc8 test failed");
		$finish;
	end

	// Offer one byte and hold it until the transaction completes.
	task automatic push_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(b);
	endtask

	task automatic send_frame(input scan_frame_t f, input bit bad_crc, input int keep);
		logic [7:0] pkt [$];
		logic [7:0] c;
		int         n;
		pkt = {HDR_BYTE, VERLEN_BYTE, f.speed[7:0], f.speed[15:8],
		       f.start_ang[7:0], f.start_ang[15:8]};
		for (int i = 0; i < POINTS; i++) begin
			pkt.push_back(f.range_mm[i][7:0]);
			pkt.push_back(f.range_mm[i][15:8]);
			pkt.push_back(f.echo[i]);
		end
		pkt.push_back(f.end_ang[7:0]);
		pkt.push_back(f.end_ang[15:8]);
		pkt.push_back(f.tstamp[7:0]);
		pkt.push_back(f.tstamp[15:8]);
		c = 8'h00;
		foreach (pkt[i])
			c = frame_scoreboard::crc_next(c, pkt[i], sb.poly);
		if (bad_crc)
			c = c ^ 8'($urandom_range(1, 255));
		pkt.push_back(c);
		n = (keep < pkt.size()) ? keep : pkt.size();
		for (int i = 0; i < n; i++)
			push_byte(pkt[i]);
		frame_bytes += n;
	endtask

	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic scan_frame_t random_frame();
		scan_frame_t f;
		f.speed     = pick16();
		f.start_ang = pick16();
		f.end_ang   = pick16();
		f.tstamp    = pick16();
		for (int i = 0; i < POINTS; i++) begin
			f.range_mm[i] = pick16();
			f.echo[i]     = 8'(pick16());
		end
		return f;
	endfunction

	function automatic scan_frame_t flat_frame(logic [15:0] w, logic [7:0] e);
		scan_frame_t f;
		f.speed     = w;
		f.start_ang = w;
		f.end_ang   = w;
		f.tstamp    = w;
		for (int i = 0; i < POINTS; i++) begin
			f.range_mm[i] = w;
			f.echo[i]     = e;
		end
		return f;
	endfunction

	// Stop sending and let every outstanding result drain.
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_polynomial(input logic [7:0] v);
		cfg_write <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		sb.poly = v;
		cfg_write <= 1'b0;
	endtask

	task automatic run_random(input int goal);
		scan_frame_t f;
		int          start;
		int          n;
		start = frame_bytes;
		while (frame_bytes - start < goal) begin
			f = random_frame();
			case ($urandom_range(0, 9))
				0: send_frame(f, 1'b1, FRAME_BYTES);
				1: send_frame(f, 1'b0, $urandom_range(3, FRAME_BYTES - 1));
				2: begin
					// header followed by a wrong version byte
					push_byte(HDR_BYTE);
					push_byte(($urandom_range(0, 1) == 0) ? HDR_BYTE : 8'($urandom_range(0, 43)));
				end
				3: begin
					n = $urandom_range(1, 4);
					repeat (n) push_byte(8'($urandom));
				end
				default: send_frame(f, 1'b0, FRAME_BYTES);
			endcase
		end
	endtask

	// Receiver: cycle through stall patterns, with one long hold-off mid-run.
	initial begin : receiver
		int  cyc;
		int  seen;
		bit  held_off;
		cyc = 0;
		seen = 0;
		held_off = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				seen++;
			if (!held_off && seen >= 30) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				case ((cyc / 50) % 4)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
			cyc++;
		end
	end

	always @(posedge clk) begin : result_mon
		scan_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.status    = status;
			got.speed     = rotation_speed;
			got.start_ang = first_angle;
			got.end_ang   = final_angle;
			got.tstamp    = stamp;
			got.idx       = point_number;
			got.range_mm  = distance_mm;
			got.echo      = strength;
			got.last_flag = last;
			sb.check_result(got);
		end
	end

	initial begin : stimulus
		scan_frame_t f;
		logic [7:0]  polys [4];
		arst_n    = 1'b0;
		cfg_write = 1'b0;
		cfg_data  = 8'h00;
		in_valid  = 1'b0;
		rx_byte   = 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset polynomial.
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(VERLEN_BYTE);
		push_byte(HDR_BYTE);
		push_byte(HDR_BYTE);
		push_byte(VERLEN_BYTE);
		send_frame(flat_frame(16'hFFFF, 8'hFF), 1'b0, FRAME_BYTES);
		send_frame(flat_frame(16'h0000, 8'h00), 1'b1, FRAME_BYTES);
		f = random_frame();
		send_frame(f, 1'b0, FRAME_BYTES);

		polys[0] = 8'h00;
		polys[1] = 8'hFF;
		polys[2] = 8'h07;
		polys[3] = 8'($urandom);
		foreach (polys[p]) begin
			settle();
			set_polynomial(polys[p]);
			run_random(40);
		end
		settle();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("lidar_frame_parser_crc8 test passed");
		else
			$display("lidar_frame_parser_crc8 test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/lfp_pkg.sv
rtl/core/lfp_ram.sv
rtl/core/lfp_ctrl.sv
rtl/core/lfp_dpath.sv
rtl/core/lidar_frame_parser_crc8.sv
test/lidar_frame_parser_crc8_test.sv
